/* sv/ffha_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the first-fit heap allocator.
// Depends on nothing; the top level refers to it by scoped names.
package ffha_pkg;

   localparam int HEAP_BYTES_DEFAULT   = 1024;
   localparam int HEADER_BYTES_DEFAULT = 16;

   // Requests are rounded up to this alignment, and a split needs at least
   // a header plus this much room left over.
   localparam int ALIGN_BYTES = 8;
   localparam int ALIGN_MASK  = 7;

   localparam int SIZE_BITS   = 16;
   localparam int OFFSET_BITS = 10;
   localparam int WANT_BITS   = SIZE_BITS + 1;

   typedef enum logic {
      OP_ALLOC   = 1'b0,
      OP_RELEASE = 1'b1
   } op_type;

   typedef struct packed {
      logic                   operation;
      logic [SIZE_BITS-1:0]   request_size;
      logic [OFFSET_BITS-1:0] block_offset;
   } req_type;

   typedef struct packed {
      logic                   success;
      logic [OFFSET_BITS-1:0] payload_offset;
   } rsp_type;

endpackage

/* sv/first_fit_heap_allocator.sv */
`timescale 1ns / 1ps
// First-fit heap allocator; its structs and default constants come from ffha_pkg.
// The result strobe is registered at the accepting edge when no walk is needed. An allocate
// reads one header per block visited and writes one more header on a split. A release is
// rejected without a header, else absorbs each following free block up to a used one or the
// heap end. Busy is low under the strobe, so the next transaction can go at the edge that
// takes the result; the receiver cannot stall. The synchronous reset sweeps all HEAP/granule
// (128) header entries with busy high.

module first_fit_heap_allocator #(
   parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEFAULT,
   parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ffha_pkg::req_type req_data,
   output logic              rsp_valid,
   output ffha_pkg::rsp_type rsp_data
);

   // Header positions always fall on multiples of the largest power of two (up to the
   // rounding alignment) that divides the header size, so the header memory has one
   // entry per granule of that size.
   localparam int GRAN_SHIFT = (HEADER_BYTES % 8 == 0) ? 3 :
                               (HEADER_BYTES % 4 == 0) ? 2 :
                               (HEADER_BYTES % 2 == 0) ? 1 : 0;
   localparam int DEPTH = (HEAP_BYTES + (1 << GRAN_SHIFT) - 1) >> GRAN_SHIFT;
   localparam int IW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   // Payload sizes stay below the heap size; positions reach the heap end itself.
   localparam int SW    = $clog2(HEAP_BYTES);
   localparam int AW    = SW + 1;
   // Width used for comparisons against the 17-bit rounded request.
   localparam int CW    = ((AW > ffha_pkg::WANT_BITS) ? AW : ffha_pkg::WANT_BITS) + 1;
   localparam int EW    = SW + 2;

   typedef enum logic [8:0] {
      ST_CLEAR   = 9'b000000001,
      ST_IDLE    = 9'b000000010,
      ST_A_LOOK  = 9'b000000100,
      ST_A_EVAL  = 9'b000001000,
      ST_A_SPLIT = 9'b000010000,
      ST_R_LOOK  = 9'b000100000,
      ST_R_EVAL  = 9'b001000000,
      ST_R_NEXT  = 9'b010000000,
      ST_R_MERGE = 9'b100000000
   } state_type;

   // Header memory: each entry is {header present, free, payload size}.
   logic [EW-1:0] hdr_mem [DEPTH];

   state_type                state_ff, state_in;
   logic [IW-1:0]            clr_ff, clr_in;
   logic [AW-1:0]            pos_ff, pos_in;
   logic [AW-1:0]            base_ff, base_in;
   logic [SW-1:0]            acc_ff, acc_in;
   logic [ffha_pkg::WANT_BITS-1:0] want_ff, want_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   ffha_pkg::rsp_type        rsp_data_ff, rsp_data_in;
   logic [EW-1:0]            rd_data_ff;

   logic                     rd_en;
   logic                     wr_en;
   logic [IW-1:0]            wr_idx;
   logic [EW-1:0]            wr_data;

   logic                     rd_head;
   logic                     rd_free;
   logic [SW-1:0]            rd_size;

   logic [AW-1:0]            step_base;
   logic [CW-1:0]            step_sum;
   logic                     pos_at_end;
   logic [CW-1:0]            want_cw;
   logic [CW-1:0]            rel_h_cw;
   logic [CW-1:0]            want_round;

   function automatic logic [IW-1:0] to_idx(input logic [AW-1:0] pos);
      return IW'(pos >> GRAN_SHIFT);
   endfunction

   assign rd_head = rd_data_ff[SW+1];
   assign rd_free = rd_data_ff[SW];
   assign rd_size = rd_data_ff[SW-1:0];

   // The walk adder: header position plus header plus payload size gives the next header.
   // It is shared by the allocate walk, the release start and every coalescing step.
   assign step_base  = (state_ff == ST_R_EVAL) ? base_ff : pos_ff;
   assign step_sum   = CW'(step_base) + CW'(HEADER_BYTES) + CW'(rd_size);
   assign pos_at_end = CW'(pos_ff) >= CW'(HEAP_BYTES);
   assign want_cw    = CW'(want_ff);
   assign rel_h_cw   = CW'(req_data.block_offset) - CW'(HEADER_BYTES);
   assign want_round = (CW'(req_data.request_size) + CW'(ffha_pkg::ALIGN_MASK))
                       & ~CW'(ffha_pkg::ALIGN_MASK);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      pos_in       = pos_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      want_in      = want_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = '0;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_idx       = '0;
      wr_data      = '0;

      case (state_ff)
         ST_CLEAR: begin
            // One entry per cycle; entry 0 becomes the single free block spanning the heap.
            wr_en  = 1'b1;
            wr_idx = clr_ff;
            if (clr_ff == '0) begin
               wr_data = {1'b1, 1'b1, SW'(HEAP_BYTES - HEADER_BYTES)};
            end
            if (clr_ff == IW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + IW'(1);
            end
         end

         ST_IDLE: begin
            if (start) begin
               if (req_data.operation == ffha_pkg::OP_ALLOC) begin
                  if (req_data.request_size == '0) begin
                     // A zero-byte allocate fails at once.
                     rsp_valid_in = 1'b1;
                  end else begin
                     want_in  = ffha_pkg::WANT_BITS'(want_round);
                     pos_in   = '0;
                     state_in = ST_A_LOOK;
                  end
               end else begin
                  if (req_data.block_offset == '0) begin
                     // Releasing null is a no-op that reports success.
                     rsp_valid_in        = 1'b1;
                     rsp_data_in.success = 1'b1;
                  end else if ((CW'(req_data.block_offset) < CW'(HEADER_BYTES)) ||
                               (rel_h_cw >= CW'(HEAP_BYTES)) ||
                               (((rel_h_cw >> GRAN_SHIFT) << GRAN_SHIFT) != rel_h_cw)) begin
                     // The header would lie outside the heap or off the header grid.
                     rsp_valid_in = 1'b1;
                  end else begin
                     pos_in   = AW'(rel_h_cw);
                     base_in  = AW'(rel_h_cw);
                     state_in = ST_R_LOOK;
                  end
               end
            end
         end

         ST_A_LOOK: begin
            if (pos_at_end) begin
               // Walked off the end of the heap: nothing fits.
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_A_EVAL;
            end
         end

         ST_A_EVAL: begin
            if (rd_free && (CW'(rd_size) >= want_cw)) begin
               if (CW'(rd_size) >= want_cw + CW'(HEADER_BYTES) + CW'(ffha_pkg::ALIGN_BYTES))
               begin
                  // Split: the tail becomes a new free block; the head is written next cycle.
                  wr_en    = 1'b1;
                  wr_idx   = to_idx(AW'(CW'(pos_ff) + CW'(HEADER_BYTES) + want_cw));
                  wr_data  = {1'b1, 1'b1,
                              SW'(CW'(rd_size) - want_cw - CW'(HEADER_BYTES))};
                  acc_in   = SW'(want_ff);
                  state_in = ST_A_SPLIT;
               end else begin
                  wr_en                      = 1'b1;
                  wr_idx                     = to_idx(pos_ff);
                  wr_data                    = {1'b1, 1'b0, rd_size};
                  rsp_valid_in               = 1'b1;
                  rsp_data_in.success        = 1'b1;
                  rsp_data_in.payload_offset =
                     ffha_pkg::OFFSET_BITS'(CW'(pos_ff) + CW'(HEADER_BYTES));
                  state_in                   = ST_IDLE;
               end
            end else begin
               pos_in   = AW'(step_sum);
               state_in = ST_A_LOOK;
            end
         end

         ST_A_SPLIT: begin
            wr_en                      = 1'b1;
            wr_idx                     = to_idx(pos_ff);
            wr_data                    = {1'b1, 1'b0, acc_ff};
            rsp_valid_in               = 1'b1;
            rsp_data_in.success        = 1'b1;
            rsp_data_in.payload_offset =
               ffha_pkg::OFFSET_BITS'(CW'(pos_ff) + CW'(HEADER_BYTES));
            state_in                   = ST_IDLE;
         end

         ST_R_LOOK: begin
            rd_en    = 1'b1;
            state_in = ST_R_EVAL;
         end

         ST_R_EVAL: begin
            if (!rd_head) begin
               // No block starts here: the release is rejected.
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               // The freed header is written once, at the end, with the merged size.
               acc_in   = rd_size;
               pos_in   = AW'(step_sum);
               state_in = ST_R_NEXT;
            end
         end

         ST_R_NEXT: begin
            if (pos_at_end) begin
               wr_en               = 1'b1;
               wr_idx              = to_idx(base_ff);
               wr_data             = {1'b1, 1'b1, acc_ff};
               rsp_valid_in        = 1'b1;
               rsp_data_in.success = 1'b1;
               state_in            = ST_IDLE;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_R_MERGE;
            end
         end

         ST_R_MERGE: begin
            if (rd_free) begin
               // Absorb the following free block and erase its header.
               wr_en    = 1'b1;
               wr_idx   = to_idx(pos_ff);
               wr_data  = '0;
               acc_in   = SW'(CW'(acc_ff) + CW'(HEADER_BYTES) + CW'(rd_size));
               pos_in   = AW'(step_sum);
               state_in = ST_R_NEXT;
            end else begin
               wr_en               = 1'b1;
               wr_idx              = to_idx(base_ff);
               wr_data             = {1'b1, 1'b1, acc_ff};
               rsp_valid_in        = 1'b1;
               rsp_data_in.success = 1'b1;
               state_in            = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      base_ff     <= base_in;
      acc_ff      <= acc_in;
      want_ff     <= want_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Single-port header memory with a registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         hdr_mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= hdr_mem[to_idx(pos_ff)];
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // Every answer is issued on the way back to idle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == ST_IDLE))
      else $error("result strobe outside idle");

   // An accepted transaction either answers at once or starts a walk.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted transaction produced neither a walk nor a result");

   // A failed transaction never reports a payload offset.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.success) |-> (rsp_data.payload_offset == '0))
      else $error("failure carries a nonzero offset");

   // The header memory is only written while a walk or the reset sweep runs.
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff != ST_IDLE))
      else $error("header memory written while idle");
`endif

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for first_fit_heap_allocator: directed and random heap traffic.
// A heap predictor in the bench checks every result. Depends on ffha_pkg and the RTL only.

module testbench;

   // The predictor works on the default heap geometry that the instance uses.
   localparam int unsigned HEAP = ffha_pkg::HEAP_BYTES_DEFAULT;
   localparam int unsigned HDR  = ffha_pkg::HEADER_BYTES_DEFAULT;

   // This pause covers the longest walk with room to spare, so a stray result after the
   // last expected one is still caught.
   localparam int DRAIN_CYCLES = 200;

   // The limit covers the slowest correct run: about 950 transactions, each with a walk and
   // a random gap, plus the header sweep after reset.
   localparam int LIMIT_CYCLES = 600000;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   ffha_pkg::req_type req_data;
   logic              rsp_valid;
   ffha_pkg::rsp_type rsp_data;

   first_fit_heap_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Heap predictor state, indexed by header byte offset: a header-present flag, a free
   // flag and the payload size of the block whose header starts there.
   logic        heap_hdr  [HEAP];
   logic        heap_free [HEAP];
   int unsigned blk_bytes [HEAP];

   // Results that the predictor expects, oldest first.
   ffha_pkg::rsp_type pending_answers[$];

   int  error_count      = 0;
   int  results_checked  = 0;
   int  alloc_count      = 0;
   int  alloc_refused    = 0;
   int  release_count    = 0;
   int  release_rejected = 0;
   int  cycle_count      = 0;
   bit  steady           = 1'b0;   // when set, the sender issues back to back

   function automatic void heap_model_reset();
      for (int i = 0; i < HEAP; i++) begin
         heap_hdr[i]  = 1'b0;
         heap_free[i] = 1'b0;
         blk_bytes[i] = 0;
      end
      heap_hdr[0]  = 1'b1;
      heap_free[0] = 1'b1;
      blk_bytes[0] = HEAP - HDR;
   endfunction

   // First-fit walk from offset 0. Returns the payload offset, or 0 for a zero size or when nothing fits.
   function automatic int unsigned heap_allocate(int unsigned want);
      int unsigned h;
      int unsigned rest;
      if (want == 0)
         return 0;
      want = (want + ffha_pkg::ALIGN_MASK) & ~ffha_pkg::ALIGN_MASK;
      h = 0;
      while (h < HEAP) begin
         if (heap_free[h] && blk_bytes[h] >= want) begin
            // Split only when the leftover can hold a header and one granule.
            if (blk_bytes[h] >= want + HDR + ffha_pkg::ALIGN_BYTES) begin
               rest            = h + HDR + want;
               heap_hdr[rest]  = 1'b1;
               heap_free[rest] = 1'b1;
               blk_bytes[rest] = blk_bytes[h] - want - HDR;
               blk_bytes[h]    = want;
            end
            heap_free[h] = 1'b0;
            return h + HDR;
         end
         h = h + HDR + blk_bytes[h];
      end
      return 0;
   endfunction

   // Marks the block free and swallows every free block that directly follows it.
   function automatic bit heap_release(int unsigned off);
      int unsigned h;
      int unsigned nxt;
      if (off == 0)
         return 1'b1;
      if (off < HDR)
         return 1'b0;
      h = off - HDR;
      if (h >= HEAP || !heap_hdr[h])
         return 1'b0;
      heap_free[h] = 1'b1;
      nxt = h + HDR + blk_bytes[h];
      while (nxt < HEAP && heap_free[nxt]) begin
         blk_bytes[h]   = blk_bytes[h] + HDR + blk_bytes[nxt];
         heap_hdr[nxt]  = 1'b0;
         heap_free[nxt] = 1'b0;
         blk_bytes[nxt] = 0;
         nxt = h + HDR + blk_bytes[h];
      end
      return 1'b1;
   endfunction

   function automatic ffha_pkg::rsp_type predict_answer(ffha_pkg::req_type item);
      ffha_pkg::rsp_type r;
      int unsigned       p;
      if (item.operation == ffha_pkg::OP_ALLOC) begin
         p = heap_allocate(item.request_size);
         r.success        = (p != 0);
         r.payload_offset = p[ffha_pkg::OFFSET_BITS-1:0];
         alloc_count++;
         if (p == 0)
            alloc_refused++;
      end else begin
         r.success        = heap_release(item.block_offset);
         r.payload_offset = '0;
         release_count++;
         if (!r.success)
            release_rejected++;
      end
      return r;
   endfunction

   function automatic ffha_pkg::req_type make_req(ffha_pkg::op_type op, int unsigned size,
                                                  int unsigned off);
      ffha_pkg::req_type r;
      r.operation    = op;
      r.request_size = size[ffha_pkg::SIZE_BITS-1:0];
      r.block_offset = off[ffha_pkg::OFFSET_BITS-1:0];
      return r;
   endfunction

   // Walks the predicted chain and returns the payload offset of a random block that is
   // free (want_free set) or allocated, or 0 when there is none.
   function automatic int unsigned pick_block(bit want_free);
      int unsigned h;
      int unsigned hits;
      int unsigned choice;
      hits = 0;
      for (h = 0; h < HEAP; h = h + HDR + blk_bytes[h])
         if (heap_free[h] == want_free)
            hits++;
      if (hits == 0)
         return 0;
      choice = $urandom_range(0, hits - 1);
      for (h = 0; h < HEAP; h = h + HDR + blk_bytes[h])
         if (heap_free[h] == want_free) begin
            if (choice == 0)
               return h + HDR;
            choice--;
         end
      return 0;
   endfunction

   // Mostly no gap or a short one, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (steady)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Presents one transaction and holds it until the block takes it. The prediction is
   // made at the accepting edge, so callers see the heap as it stands afterwards. With no
   // gap, start stays high and the next call simply replaces the payload.
   task automatic issue(input ffha_pkg::req_type item, output ffha_pkg::rsp_type predicted);
      int unsigned gap;
      req_data <= item;
      start    <= 1'b1;
      do
         @(posedge clock);
      while (busy);
      predicted = predict_answer(item);
      pending_answers.push_back(predicted);
      gap = pick_gap();
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Zero size, oversize, an exact whole-heap fit, nothing fits, null, bogus and double
   // releases, and splits with and without leftover room.
   task automatic test_directed_cases();
      ffha_pkg::rsp_type got;
      issue(make_req(ffha_pkg::OP_ALLOC, 0, $urandom), got);
      issue(make_req(ffha_pkg::OP_ALLOC, 16'hFFFF, $urandom), got);
      issue(make_req(ffha_pkg::OP_ALLOC, HEAP - HDR + 1, $urandom), got);
      issue(make_req(ffha_pkg::OP_ALLOC, HEAP - HDR, $urandom), got);
      issue(make_req(ffha_pkg::OP_ALLOC, 1, $urandom), got);
      issue(make_req(ffha_pkg::OP_RELEASE, $urandom, HDR), got);
      issue(make_req(ffha_pkg::OP_RELEASE, $urandom, HDR), got);
      issue(make_req(ffha_pkg::OP_RELEASE, $urandom, 0), got);
      issue(make_req(ffha_pkg::OP_RELEASE, $urandom, 5), got);
      issue(make_req(ffha_pkg::OP_RELEASE, $urandom, 1023), got);
      issue(make_req(ffha_pkg::OP_RELEASE, $urandom, 40), got);
      issue(make_req(ffha_pkg::OP_ALLOC, 1, $urandom), got);
      issue(make_req(ffha_pkg::OP_ALLOC, 100, $urandom), got);
      issue(make_req(ffha_pkg::OP_ALLOC, 8, $urandom), got);
      issue(make_req(ffha_pkg::OP_RELEASE, $urandom, 56), got);
      // Releasing the first block finds the block right behind it in use, so nothing is absorbed.
      issue(make_req(ffha_pkg::OP_RELEASE, $urandom, HDR), got);
      // This allocate skips the small first block and splits the free block at the heap end.
      issue(make_req(ffha_pkg::OP_ALLOC, 120, $urandom), got);
      issue(make_req(ffha_pkg::OP_RELEASE, $urandom, 176), got);
      issue(make_req(ffha_pkg::OP_RELEASE, $urandom, HDR), got);
      // Asks for the whole-heap payload less a header and one granule; no free block holds that.
      issue(make_req(ffha_pkg::OP_ALLOC, HEAP - 2 * HDR - ffha_pkg::ALIGN_BYTES, $urandom),
            got);
      issue(make_req(ffha_pkg::OP_ALLOC, 8, $urandom), got);
      issue(make_req(ffha_pkg::OP_ALLOC, 1, $urandom), got);
      issue(make_req(ffha_pkg::OP_RELEASE, $urandom, HEAP - ffha_pkg::ALIGN_BYTES), got);
      issue(make_req(ffha_pkg::OP_RELEASE, $urandom, HDR), got);
   endtask

   // Fills the heap with small blocks until an allocate is refused, then frees them all
   // in random order, sometimes twice, so coalescing runs over long chains.
   task automatic test_fill_and_drain(input int unsigned max_size);
      ffha_pkg::rsp_type got;
      int unsigned       live[$];
      int unsigned       idx;
      do begin
         issue(make_req(ffha_pkg::OP_ALLOC, $urandom_range(1, max_size), $urandom), got);
         if (got.success)
            live.push_back(got.payload_offset);
      end while (got.success);
      while (live.size() != 0) begin
         idx = $urandom_range(0, live.size() - 1);
         issue(make_req(ffha_pkg::OP_RELEASE, $urandom, live[idx]), got);
         if ($urandom_range(0, 7) == 0)
            issue(make_req(ffha_pkg::OP_RELEASE, $urandom, live[idx]), got);
         live.delete(idx);
      end
   endtask

   // Well-formed traffic with random content: allocates of mixed sizes and releases of
   // blocks that are really in use, salted with double, null and bogus releases.
   task automatic test_random_churn(input int count);
      ffha_pkg::rsp_type got;
      int unsigned       roll;
      int unsigned       size;
      int unsigned       off;
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0)
            steady = ($urandom_range(0, 3) == 0);
         roll = $urandom_range(0, 99);
         off  = pick_block(1'b0);
         if (roll < 50 || (roll < 90 && off == 0)) begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
               size = $urandom_range(1, 64);
            else if (roll < 90)
               size = $urandom_range(65, 400);
            else if (roll < 97)
               size = $urandom_range(401, HEAP - HDR);
            else
               size = $urandom_range(0, 16'hFFFF);
            issue(make_req(ffha_pkg::OP_ALLOC, size, $urandom), got);
         end else if (roll < 90) begin
            issue(make_req(ffha_pkg::OP_RELEASE, $urandom, off), got);
         end else if (roll < 94) begin
            issue(make_req(ffha_pkg::OP_RELEASE, $urandom, pick_block(1'b1)), got);
         end else if (roll < 97) begin
            issue(make_req(ffha_pkg::OP_RELEASE, $urandom, 0), got);
         end else begin
            issue(make_req(ffha_pkg::OP_RELEASE, $urandom, $urandom_range(1, 1023)), got);
         end
      end
      steady = 1'b0;
   endtask

   // Fully random transactions: every field bit toggles, most releases are bogus.
   task automatic test_random_noise(input int count);
      ffha_pkg::rsp_type got;
      ffha_pkg::req_type item;
      int unsigned       raw;
      for (int n = 0; n < count; n++) begin
         raw  = $urandom;
         item = raw[$bits(ffha_pkg::req_type)-1:0];
         issue(item, got);
      end
   endtask

   // Every result is compared with the oldest prediction. The receiver cannot stall, so
   // each strobed cycle is one accepted result.
   always @(posedge clock) begin : check_results
      ffha_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         results_checked++;
         if (pending_answers.size() == 0) begin
            $error("result with nothing expected: success=%0d payload_offset=%0d",
                   rsp_data.success, rsp_data.payload_offset);
            error_count++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_data.success !== want.success) begin
               $error("success: expected %0d, actual %0d", want.success, rsp_data.success);
               error_count++;
            end
            if (rsp_data.payload_offset !== want.payload_offset) begin
               $error("payload_offset: expected %0d, actual %0d",
                      want.payload_offset, rsp_data.payload_offset);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles, %0d results outstanding.",
                  cycle_count, pending_answers.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      heap_model_reset();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // The block sweeps its header memory after reset with busy high; the first
      // transaction simply waits that out.
      test_directed_cases();
      test_fill_and_drain(8);
      test_fill_and_drain(64);
      test_random_churn(600);
      test_random_noise(150);

      start <= 1'b0;
      while (pending_answers.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d allocates (%0d refused) and %0d releases (%0d rejected).",
               alloc_count, alloc_refused, release_count, release_rejected);
      $display("%0d results checked in %0d cycles.", results_checked, cycle_count);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
